// ===== src/bru_pkg.sv =====
// shared types and codes of the branch resolve unit
package bru_pkg;

    localparam int ADDR_W = 16;
    localparam int BYTE_W = 8;
    localparam int CYC_W  = 5;

    // operation codes
    localparam logic [2:0] OP_JR    = 3'd0;
    localparam logic [2:0] OP_JP    = 3'd1;
    localparam logic [2:0] OP_CALL  = 3'd2;
    localparam logic [2:0] OP_RET   = 3'd3;
    localparam logic [2:0] OP_RETI  = 3'd4;
    localparam logic [2:0] OP_RST   = 3'd5;
    localparam logic [2:0] OP_JP_HL = 3'd6;

    // condition codes
    localparam logic [2:0] COND_ALWAYS = 3'd0;
    localparam logic [2:0] COND_NZ     = 3'd1;
    localparam logic [2:0] COND_Z      = 3'd2;
    localparam logic [2:0] COND_NC     = 3'd3;
    localparam logic [2:0] COND_C      = 3'd4;

    // cycle counts
    localparam logic [CYC_W-1:0] CYC_4  = 5'd4;
    localparam logic [CYC_W-1:0] CYC_8  = 5'd8;
    localparam logic [CYC_W-1:0] CYC_12 = 5'd12;
    localparam logic [CYC_W-1:0] CYC_16 = 5'd16;
    localparam logic [CYC_W-1:0] CYC_20 = 5'd20;
    localparam logic [CYC_W-1:0] CYC_24 = 5'd24;

    localparam logic [ADDR_W-1:0] ONE   = 16'd1;
    localparam logic [ADDR_W-1:0] TWO   = 16'd2;
    localparam logic [ADDR_W-1:0] THREE = 16'd3;

    // decode stage output
    typedef struct packed {
        logic [2:0]        operation;
        logic              cond_ok;
        logic              cond_always;
        logic [2:0]        rst_index;
        logic [ADDR_W-1:0] prog_counter;
        logic [ADDR_W-1:0] stack_ptr;
        logic [BYTE_W-1:0] imm_low;
        logic [BYTE_W-1:0] imm_high;
        logic [ADDR_W-1:0] hl_value;
        logic [ADDR_W-1:0] popped_word;
    } dec_t;

    // address stage output
    typedef struct packed {
        logic [2:0]        operation;
        logic              cond_ok;
        logic              cond_always;
        logic [ADDR_W-1:0] abs_target;
        logic [ADDR_W-1:0] rst_target;
        logic [ADDR_W-1:0] rel_target;
        logic [ADDR_W-1:0] hl_value;
        logic [ADDR_W-1:0] popped_word;
        logic [ADDR_W-1:0] pc_plus1;
        logic [ADDR_W-1:0] pc_plus2;
        logic [ADDR_W-1:0] pc_plus3;
        logic [ADDR_W-1:0] stack_ptr;
        logic [ADDR_W-1:0] sp_minus2;
        logic [ADDR_W-1:0] sp_plus2;
    } addr_t;

    // resolved transaction
    typedef struct packed {
        logic [ADDR_W-1:0] next_pc;
        logic [ADDR_W-1:0] next_sp;
        logic              taken;
        logic              push_enable;
        logic [ADDR_W-1:0] push_address;
        logic [ADDR_W-1:0] push_word;
        logic [CYC_W-1:0]  cycle_count;
        logic              enable_interrupts;
    } res_t;

endpackage

// ===== src/bru_decode.sv =====
// stage one: condition evaluation and operand capture
module bru_decode
    import bru_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  dec_t        in_data,
    input  logic [2:0]  condition,
    input  logic        zero_flag,
    input  logic        carry_flag,
    output logic        out_valid,
    input  logic        out_ready,
    output dec_t        out_data
);

    logic valid_reg;
    dec_t data_reg;
    dec_t data_next;
    logic cond_hold;

    // reserved condition codes act as always
    always_comb
    begin
        case (condition)
            COND_NZ: cond_hold = !zero_flag;
            COND_Z:  cond_hold = zero_flag;
            COND_NC: cond_hold = !carry_flag;
            COND_C:  cond_hold = carry_flag;
            default: cond_hold = 1'b1;
        endcase
    end

    always_comb
    begin
        data_next             = in_data;
        data_next.cond_ok     = cond_hold;
        data_next.cond_always = (condition == COND_ALWAYS) || (condition > COND_C);
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            data_reg <= data_next;
    end

endmodule

// ===== src/bru_address.sv =====
// stage two: target and stack address adders
module bru_address
    import bru_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_ready,
    input  dec_t  in_data,
    output logic  out_valid,
    input  logic  out_ready,
    output addr_t out_data
);

    logic              valid_reg;
    addr_t             data_reg;
    addr_t             data_next;
    logic [ADDR_W-1:0] offset;

    // relative offset sign-extended to a full address
    assign offset = {{(ADDR_W-BYTE_W){in_data.imm_low[BYTE_W-1]}}, in_data.imm_low};

    always_comb
    begin
        data_next.operation   = in_data.operation;
        data_next.cond_ok     = in_data.cond_ok;
        data_next.cond_always = in_data.cond_always;
        data_next.abs_target  = {in_data.imm_high, in_data.imm_low};
        // restart vector is index times eight
        data_next.rst_target  = {{(ADDR_W-6){1'b0}}, in_data.rst_index, 3'b000};
        data_next.rel_target  = in_data.prog_counter + TWO + offset;
        data_next.hl_value    = in_data.hl_value;
        data_next.popped_word = in_data.popped_word;
        data_next.pc_plus1    = in_data.prog_counter + ONE;
        data_next.pc_plus2    = in_data.prog_counter + TWO;
        data_next.pc_plus3    = in_data.prog_counter + THREE;
        data_next.stack_ptr   = in_data.stack_ptr;
        data_next.sp_minus2   = in_data.stack_ptr - TWO;
        data_next.sp_plus2    = in_data.stack_ptr + TWO;
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            data_reg <= data_next;
    end

endmodule

// ===== src/bru_select.sv =====
// stage three: result selection and output register
module bru_select
    import bru_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_ready,
    input  addr_t in_data,
    output logic  out_valid,
    input  logic  out_ready,
    output res_t  out_data
);

    logic valid_reg;
    res_t data_reg;
    res_t data_next;

    always_comb
    begin
        data_next.next_pc           = in_data.pc_plus1;
        data_next.next_sp           = in_data.stack_ptr;
        data_next.taken             = 1'b0;
        data_next.push_enable       = 1'b0;
        data_next.push_address      = '0;
        data_next.push_word         = '0;
        data_next.cycle_count       = CYC_4;
        data_next.enable_interrupts = 1'b0;
        case (in_data.operation)
            OP_JR:
            begin
                if (in_data.cond_ok)
                begin
                    data_next.next_pc     = in_data.rel_target;
                    data_next.taken       = 1'b1;
                    data_next.cycle_count = CYC_12;
                end
                else
                begin
                    data_next.next_pc     = in_data.pc_plus2;
                    data_next.cycle_count = CYC_8;
                end
            end
            OP_JP:
            begin
                if (in_data.cond_ok)
                begin
                    data_next.next_pc     = in_data.abs_target;
                    data_next.taken       = 1'b1;
                    data_next.cycle_count = CYC_16;
                end
                else
                begin
                    data_next.next_pc     = in_data.pc_plus3;
                    data_next.cycle_count = CYC_12;
                end
            end
            OP_CALL:
            begin
                if (in_data.cond_ok)
                begin
                    data_next.next_pc      = in_data.abs_target;
                    data_next.next_sp      = in_data.sp_minus2;
                    data_next.taken        = 1'b1;
                    data_next.push_enable  = 1'b1;
                    data_next.push_address = in_data.sp_minus2;
                    data_next.push_word    = in_data.pc_plus3;
                    data_next.cycle_count  = CYC_24;
                end
                else
                begin
                    data_next.next_pc     = in_data.pc_plus3;
                    data_next.cycle_count = CYC_12;
                end
            end
            OP_RET:
            begin
                if (in_data.cond_ok)
                begin
                    data_next.next_pc     = in_data.popped_word;
                    data_next.next_sp     = in_data.sp_plus2;
                    data_next.taken       = 1'b1;
                    data_next.cycle_count = in_data.cond_always ? CYC_16 : CYC_20;
                end
                else
                begin
                    data_next.cycle_count = CYC_8;
                end
            end
            OP_RETI:
            begin
                data_next.next_pc           = in_data.popped_word;
                data_next.next_sp           = in_data.sp_plus2;
                data_next.taken             = 1'b1;
                data_next.cycle_count       = CYC_16;
                data_next.enable_interrupts = 1'b1;
            end
            OP_RST:
            begin
                data_next.next_pc      = in_data.rst_target;
                data_next.next_sp      = in_data.sp_minus2;
                data_next.taken        = 1'b1;
                data_next.push_enable  = 1'b1;
                data_next.push_address = in_data.sp_minus2;
                data_next.push_word    = in_data.pc_plus1;
                data_next.cycle_count  = CYC_16;
            end
            OP_JP_HL:
            begin
                data_next.next_pc = in_data.hl_value;
                data_next.taken   = 1'b1;
            end
            // unused opcode behaves as a one-byte no-op
            default: ;
        endcase
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            data_reg <= data_next;
    end

`ifndef SYNTHESIS
    a_push_sp: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && data_reg.push_enable |->
            data_reg.next_sp == data_reg.push_address && data_reg.taken)
        else $error("push address does not match new stack pointer");

    a_no_push_zero: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && !data_reg.push_enable |->
            data_reg.push_address == '0 && data_reg.push_word == '0)
        else $error("push fields not cleared without a push");

    a_ei_reti: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && data_reg.enable_interrupts |->
            data_reg.taken && data_reg.cycle_count == CYC_16)
        else $error("interrupt enable without a taken return");

    a_cycle_range: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |-> data_reg.cycle_count >= CYC_4 && data_reg.cycle_count <= CYC_24)
        else $error("cycle count out of range");
`endif

endmodule

// ===== src/branch_resolve_unit.sv =====
// top level of the branch resolve unit
// Resolves one control-transfer instruction (jr, jp, call, ret, reti, rst,
// jp hl) per clock cycle while the output side does not stall. The work
// runs through three register stages: condition decode, the address adders,
// and result selection into the output register, so a transaction accepted
// at the input is held in the decode, address and output registers in turn
// before it is presented on the result ports. Each stage holds its item
// while the output side stalls; ready passes back through the stages
// combinationally, so the pipeline stays full under back-pressure.
module branch_resolve_unit
    import bru_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_ready,
    input  logic [2:0]        operation,
    input  logic [2:0]        condition,
    input  logic [2:0]        rst_index,
    input  logic [ADDR_W-1:0] prog_counter,
    input  logic [ADDR_W-1:0] stack_ptr,
    input  logic              zero_flag,
    input  logic              carry_flag,
    input  logic [BYTE_W-1:0] imm_low,
    input  logic [BYTE_W-1:0] imm_high,
    input  logic [ADDR_W-1:0] hl_value,
    input  logic [ADDR_W-1:0] popped_word,
    output logic              result_valid,
    input  logic              result_ready,
    output logic [ADDR_W-1:0] next_pc,
    output logic [ADDR_W-1:0] next_sp,
    output logic              taken,
    output logic              push_enable,
    output logic [ADDR_W-1:0] push_address,
    output logic [ADDR_W-1:0] push_word,
    output logic [CYC_W-1:0]  cycle_count,
    output logic              enable_interrupts
);

    dec_t  in_pack;
    dec_t  dec_data;
    addr_t addr_data;
    res_t  res_data;
    logic  dec_valid;
    logic  dec_ready;
    logic  addr_valid;
    logic  addr_ready;

    always_comb
    begin
        in_pack              = '0;
        in_pack.operation    = operation;
        in_pack.rst_index    = rst_index;
        in_pack.prog_counter = prog_counter;
        in_pack.stack_ptr    = stack_ptr;
        in_pack.imm_low      = imm_low;
        in_pack.imm_high     = imm_high;
        in_pack.hl_value     = hl_value;
        in_pack.popped_word  = popped_word;
        in_pack.cond_ok      = 1'b0;
        in_pack.cond_always  = 1'b0;
    end

    bru_decode u_decode (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (item_valid),
        .in_ready   (item_ready),
        .in_data    (in_pack),
        .condition  (condition),
        .zero_flag  (zero_flag),
        .carry_flag (carry_flag),
        .out_valid  (dec_valid),
        .out_ready  (dec_ready),
        .out_data   (dec_data)
    );

    bru_address u_address (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (dec_valid),
        .in_ready  (dec_ready),
        .in_data   (dec_data),
        .out_valid (addr_valid),
        .out_ready (addr_ready),
        .out_data  (addr_data)
    );

    bru_select u_select (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (addr_valid),
        .in_ready  (addr_ready),
        .in_data   (addr_data),
        .out_valid (result_valid),
        .out_ready (result_ready),
        .out_data  (res_data)
    );

    assign next_pc           = res_data.next_pc;
    assign next_sp           = res_data.next_sp;
    assign taken             = res_data.taken;
    assign push_enable       = res_data.push_enable;
    assign push_address      = res_data.push_address;
    assign push_word         = res_data.push_word;
    assign cycle_count       = res_data.cycle_count;
    assign enable_interrupts = res_data.enable_interrupts;

endmodule

// ===== tb/tb_branch_resolve_unit.sv =====
// self-checking testbench for branch_resolve_unit: directed corners, random traffic, stalls
`timescale 1ns / 100ps

module tb_branch_resolve_unit
    import bru_pkg::*;
();

    // codes outside the package's named set, still legal on the ports
    localparam logic [2:0] OP_UNUSED  = 3'd7;
    localparam logic [2:0] COND_RSVD5 = 3'd5;
    localparam logic [2:0] COND_RSVD6 = 3'd6;
    localparam logic [2:0] COND_RSVD7 = 3'd7;

    localparam int RANDOM_ITEMS = 1275;
    localparam int QUIET_FROM   = 1125;
    localparam int DRAIN_AT     = 600;
    localparam int SETTLE_CYCLES = 8;

    typedef struct packed {
        logic [2:0]        operation;
        logic [2:0]        condition;
        logic [2:0]        rst_index;
        logic [ADDR_W-1:0] prog_counter;
        logic [ADDR_W-1:0] stack_ptr;
        logic              zero_flag;
        logic              carry_flag;
        logic [BYTE_W-1:0] imm_low;
        logic [BYTE_W-1:0] imm_high;
        logic [ADDR_W-1:0] hl_value;
        logic [ADDR_W-1:0] popped_word;
    } branch_insn_t;

    class branch_checker;
        res_t        resolved_q[$];
        int unsigned errors;
        int unsigned retired;
        int unsigned taken_seen;
        int unsigned pushes_seen;
        int unsigned op_seen[8];

        function res_t resolve(branch_insn_t b);
            res_t              r;
            logic              cond_ok;
            logic [ADDR_W-1:0] target;
            logic [ADDR_W-1:0] offset;
            case (b.condition)
                COND_NZ: cond_ok = !b.zero_flag;
                COND_Z:  cond_ok = b.zero_flag;
                COND_NC: cond_ok = !b.carry_flag;
                COND_C:  cond_ok = b.carry_flag;
                default: cond_ok = 1'b1;
            endcase
            target = {b.imm_high, b.imm_low};
            offset = {{BYTE_W{b.imm_low[BYTE_W-1]}}, b.imm_low};
            r = '0;
            r.next_pc = b.prog_counter + ONE;
            r.next_sp = b.stack_ptr;
            r.cycle_count = CYC_4;
            case (b.operation)
                OP_JR:
                begin
                    r.taken = cond_ok;
                    r.next_pc = b.prog_counter + TWO + (cond_ok ? offset : '0);
                    r.cycle_count = cond_ok ? CYC_12 : CYC_8;
                end
                OP_JP:
                begin
                    r.taken = cond_ok;
                    r.next_pc = cond_ok ? target : b.prog_counter + THREE;
                    r.cycle_count = cond_ok ? CYC_16 : CYC_12;
                end
                OP_CALL:
                begin
                    r.taken = cond_ok;
                    r.cycle_count = CYC_12;
                    r.next_pc = b.prog_counter + THREE;
                    if (cond_ok)
                    begin
                        r.next_pc = target;
                        r.next_sp = b.stack_ptr - TWO;
                        r.push_enable = 1'b1;
                        r.push_address = b.stack_ptr - TWO;
                        r.push_word = b.prog_counter + THREE;
                        r.cycle_count = CYC_24;
                    end
                end
                OP_RET:
                begin
                    r.taken = cond_ok;
                    r.cycle_count = CYC_8;
                    if (cond_ok)
                    begin
                        r.next_pc = b.popped_word;
                        r.next_sp = b.stack_ptr + TWO;
                        // unconditional forms skip the flag test cycle
                        r.cycle_count = (b.condition == COND_ALWAYS || b.condition > COND_C)
                                        ? CYC_16 : CYC_20;
                    end
                end
                OP_RETI:
                begin
                    r.taken = 1'b1;
                    r.next_pc = b.popped_word;
                    r.next_sp = b.stack_ptr + TWO;
                    r.cycle_count = CYC_16;
                    r.enable_interrupts = 1'b1;
                end
                OP_RST:
                begin
                    r.taken = 1'b1;
                    r.next_pc = {10'd0, b.rst_index, 3'd0};
                    r.next_sp = b.stack_ptr - TWO;
                    r.push_enable = 1'b1;
                    r.push_address = b.stack_ptr - TWO;
                    r.push_word = b.prog_counter + ONE;
                    r.cycle_count = CYC_16;
                end
                OP_JP_HL:
                begin
                    r.taken = 1'b1;
                    r.next_pc = b.hl_value;
                end
                default:
                begin
                    // unused opcode behaves as a one-byte no-op
                end
            endcase
            return r;
        endfunction

        function void note_insn(branch_insn_t b);
            resolved_q.push_back(resolve(b));
            op_seen[b.operation]++;
        endfunction

        function void report(string msg);
            errors++;
            $display("ERROR @%0t: %s", $realtime, msg);
        endfunction

        function void check_result(res_t got);
            res_t want;
            if (resolved_q.size() == 0)
            begin
                report($sformatf("transaction with nothing pending, next_pc %h", got.next_pc));
                return;
            end
            want = resolved_q.pop_front();
            if (got.next_pc !== want.next_pc)
                report($sformatf("txn %0d next_pc %h, want %h", retired, got.next_pc,
                                 want.next_pc));
            if (got.next_sp !== want.next_sp)
                report($sformatf("txn %0d next_sp %h, want %h", retired, got.next_sp,
                                 want.next_sp));
            if (got.taken !== want.taken)
                report($sformatf("txn %0d taken %b, want %b", retired, got.taken, want.taken));
            if (got.push_enable !== want.push_enable)
                report($sformatf("txn %0d push_enable %b, want %b", retired, got.push_enable,
                                 want.push_enable));
            if (got.push_address !== want.push_address)
                report($sformatf("txn %0d push_address %h, want %h", retired, got.push_address,
                                 want.push_address));
            if (got.push_word !== want.push_word)
                report($sformatf("txn %0d push_word %h, want %h", retired, got.push_word,
                                 want.push_word));
            if (got.cycle_count !== want.cycle_count)
                report($sformatf("txn %0d cycle_count %0d, want %0d", retired, got.cycle_count,
                                 want.cycle_count));
            if (got.enable_interrupts !== want.enable_interrupts)
                report($sformatf("txn %0d enable_interrupts %b, want %b", retired,
                                 got.enable_interrupts, want.enable_interrupts));
            retired++;
            taken_seen += got.taken;
            pushes_seen += got.push_enable;
        endfunction
    endclass

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              item_valid = 1'b0;
    logic              item_ready;
    logic [2:0]        operation = '0;
    logic [2:0]        condition = '0;
    logic [2:0]        rst_index = '0;
    logic [ADDR_W-1:0] prog_counter = '0;
    logic [ADDR_W-1:0] stack_ptr = '0;
    logic              zero_flag = 1'b0;
    logic              carry_flag = 1'b0;
    logic [BYTE_W-1:0] imm_low = '0;
    logic [BYTE_W-1:0] imm_high = '0;
    logic [ADDR_W-1:0] hl_value = '0;
    logic [ADDR_W-1:0] popped_word = '0;
    logic              result_valid;
    logic              result_ready = 1'b0;
    logic [ADDR_W-1:0] next_pc;
    logic [ADDR_W-1:0] next_sp;
    logic              taken;
    logic              push_enable;
    logic [ADDR_W-1:0] push_address;
    logic [ADDR_W-1:0] push_word;
    logic [CYC_W-1:0]  cycle_count;
    logic              enable_interrupts;

    branch_checker chk = new();
    bit            idling_on = 1'b1;
    int unsigned   stall_left = 0;

    branch_resolve_unit dut (.*);

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    initial
    begin
        #5_000_000;
        $display("branch_resolve_unit verification failed");
        $finish;
    end

    function automatic branch_insn_t mk(logic [2:0] op, logic [2:0] cond, logic [2:0] idx,
                                        logic [15:0] pc, logic [15:0] sp, logic z, logic c,
                                        logic [7:0] lo, logic [7:0] hi, logic [15:0] hl,
                                        logic [15:0] pop);
        branch_insn_t b;
        b = '{op, cond, idx, pc, sp, z, c, lo, hi, hl, pop};
        return b;
    endfunction

    // biased toward the wrap points of 16-bit address math
    function automatic logic [ADDR_W-1:0] corner16();
        case ($urandom_range(0, 9))
            0: return 16'h0000;
            1: return 16'hffff;
            2: return 16'hfffe;
            3: return 16'hfffd;
            4: return 16'h0001;
            default: return ADDR_W'($urandom);
        endcase
    endfunction

    function automatic branch_insn_t random_insn();
        branch_insn_t b;
        b.operation = 3'($urandom_range(0, 7));
        b.condition = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(5, 7))
                                                  : 3'($urandom_range(0, 4));
        b.rst_index = 3'($urandom_range(0, 7));
        b.prog_counter = corner16();
        b.stack_ptr = corner16();
        b.zero_flag = 1'($urandom);
        b.carry_flag = 1'($urandom);
        b.imm_low = 8'($urandom);
        b.imm_high = 8'($urandom);
        b.hl_value = corner16();
        b.popped_word = corner16();
        return b;
    endfunction

    task automatic send_insn(input branch_insn_t b);
        item_valid <= 1'b1;
        operation <= b.operation;
        condition <= b.condition;
        rst_index <= b.rst_index;
        prog_counter <= b.prog_counter;
        stack_ptr <= b.stack_ptr;
        zero_flag <= b.zero_flag;
        carry_flag <= b.carry_flag;
        imm_low <= b.imm_low;
        imm_high <= b.imm_high;
        hl_value <= b.hl_value;
        popped_word <= b.popped_word;
        do @(posedge clk); while (!item_ready);
        chk.note_insn(b);
    endtask

    task automatic pause(input int unsigned cycles);
        item_valid <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    task automatic drain();
        item_valid <= 1'b0;
        do @(posedge clk); while (chk.resolved_q.size() != 0);
    endtask

    task automatic maybe_pause();
        if (idling_on && $urandom_range(0, 4) == 0)
            pause($urandom_range(1, 17));
    endtask

    // result side: sample at the edge, then pick the next ready level
    always @(posedge clk)
    begin : result_side
        res_t seen;
        logic ready_next;
        if (rst_n && result_valid && result_ready)
        begin
            seen.next_pc = next_pc;
            seen.next_sp = next_sp;
            seen.taken = taken;
            seen.push_enable = push_enable;
            seen.push_address = push_address;
            seen.push_word = push_word;
            seen.cycle_count = cycle_count;
            seen.enable_interrupts = enable_interrupts;
            chk.check_result(seen);
        end
        if (!idling_on)
        begin
            ready_next = 1'b1;
            stall_left = 0;
        end
        else if (stall_left != 0)
        begin
            ready_next = 1'b0;
            stall_left--;
        end
        else if ($urandom_range(0, 5) == 0)
        begin
            ready_next = 1'b0;
            stall_left = $urandom_range(0, 16);
        end
        else
            ready_next = 1'b1;
        result_ready <= ready_next;
    end

    initial
    begin : stimulus
        branch_insn_t plan[$];
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        pause(2);

        plan.push_back(mk(OP_JR, COND_ALWAYS, 0, 16'h1000, 16'h8000, 0, 0, 8'h7f, 0, 0, 0));
        plan.push_back(mk(OP_JR, COND_NZ, 0, 16'h0000, 16'h8000, 0, 0, 8'h80, 0, 0, 0));
        plan.push_back(mk(OP_JR, COND_Z, 0, 16'hffff, 16'h8000, 0, 1, 8'h10, 0, 0, 0));
        plan.push_back(mk(OP_JR, COND_C, 0, 16'hfffe, 16'h8000, 1, 1, 8'h01, 0, 0, 0));
        plan.push_back(mk(OP_JP, COND_ALWAYS, 0, 16'h0150, 16'hfffe, 0, 0, 8'hff, 8'hff, 0, 0));
        plan.push_back(mk(OP_JP, COND_NC, 0, 16'hfffe, 16'hfffe, 0, 1, 8'h34, 8'h12, 0, 0));
        plan.push_back(mk(OP_JP, COND_Z, 0, 16'h4000, 16'hfffe, 1, 0, 8'h00, 8'h00, 0, 0));
        plan.push_back(mk(OP_CALL, COND_ALWAYS, 0, 16'hfffd, 16'h0000, 0, 0, 8'h00, 8'h20,
                          0, 0));
        plan.push_back(mk(OP_CALL, COND_NC, 0, 16'h1234, 16'h0001, 1, 0, 8'hcd, 8'hab, 0, 0));
        plan.push_back(mk(OP_CALL, COND_C, 0, 16'hffff, 16'hffff, 0, 1, 8'h55, 8'haa, 0, 0));
        plan.push_back(mk(OP_CALL, COND_C, 0, 16'h2000, 16'hc000, 1, 0, 8'h55, 8'haa, 0, 0));
        plan.push_back(mk(OP_CALL, COND_NZ, 0, 16'hfffe, 16'hc000, 1, 1, 8'h55, 8'haa, 0, 0));
        plan.push_back(mk(OP_RET, COND_ALWAYS, 0, 16'h3000, 16'hfffe, 0, 0, 0, 0, 0, 16'hffff));
        plan.push_back(mk(OP_RET, COND_NZ, 0, 16'h3000, 16'hffff, 0, 0, 0, 0, 0, 16'h8001));
        plan.push_back(mk(OP_RET, COND_NC, 0, 16'hffff, 16'hd000, 0, 1, 0, 0, 0, 16'h8001));
        plan.push_back(mk(OP_RET, COND_C, 0, 16'h3000, 16'hd000, 1, 1, 0, 0, 0, 16'h0000));
        plan.push_back(mk(OP_RETI, COND_Z, 0, 16'h0048, 16'hfffe, 0, 0, 0, 0, 0, 16'h1a2b));
        plan.push_back(mk(OP_RST, COND_NZ, 0, 16'hffff, 16'h0001, 1, 0, 0, 0, 0, 0));
        plan.push_back(mk(OP_RST, COND_ALWAYS, 7, 16'h7ffe, 16'h0000, 0, 0, 0, 0, 0, 0));
        plan.push_back(mk(OP_JP_HL, COND_NC, 0, 16'h0200, 16'h8000, 0, 1, 0, 0, 16'hffff, 0));
        plan.push_back(mk(OP_JP_HL, COND_ALWAYS, 0, 16'h0200, 16'h8000, 0, 0, 0, 0, 0, 0));
        plan.push_back(mk(OP_JP, COND_RSVD5, 0, 16'h0300, 16'h8000, 1, 1, 8'hef, 8'hbe, 0, 0));
        plan.push_back(mk(OP_RET, COND_RSVD6, 0, 16'h0300, 16'h8000, 1, 1, 0, 0, 0, 16'h0c0d));
        plan.push_back(mk(OP_JR, COND_RSVD7, 0, 16'h0300, 16'h8000, 0, 1, 8'hfe, 0, 0, 0));
        plan.push_back(mk(OP_UNUSED, COND_Z, 3, 16'hffff, 16'h8000, 0, 0, 8'h11, 8'h22,
                          16'h3333, 16'h4444));

        foreach (plan[i])
        begin
            send_insn(plan[i]);
            maybe_pause();
        end
        drain();

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n == QUIET_FROM)
                idling_on = 1'b0;
            else if (n < QUIET_FROM && n % 100 == 0)
                idling_on = ($urandom_range(0, 3) != 0);
            // hold off until the pipeline has fully emptied
            if (n == DRAIN_AT)
                drain();
            send_insn(random_insn());
            maybe_pause();
        end

        drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (chk.resolved_q.size() != 0)
            chk.report("expected transaction never arrived");

        $display("covered %0d transactions: %0d taken, %0d with a stack push", chk.retired,
                 chk.taken_seen, chk.pushes_seen);
        $display("mix jr %0d jp %0d call %0d ret %0d reti %0d rst %0d jp-hl %0d unused %0d",
                 chk.op_seen[0], chk.op_seen[1], chk.op_seen[2], chk.op_seen[3],
                 chk.op_seen[4], chk.op_seen[5], chk.op_seen[6], chk.op_seen[7]);
        if (chk.errors == 0)
            $display("branch_resolve_unit verification clean");
        else
            $display("branch_resolve_unit verification failed");
        $finish;
    end

endmodule

// ===== branch_resolve_unit.f =====
src/bru_pkg.sv
src/bru_decode.sv
src/bru_address.sv
src/bru_select.sv
src/branch_resolve_unit.sv
tb/tb_branch_resolve_unit.sv
